>>> hw/rtl/dcst_pkg.sv
// ----------------------------------------------------------------------------
// dcst_pkg: shared types and constants of the stereo DC tracker
// Item structures, configuration register indexes and reset values, and the
// frame length used by the frame counter.
// ----------------------------------------------------------------------------
`default_nettype none

package dcst_pkg;

  // Number of stereo pairs in one output frame.
  localparam int unsigned FRAME_PAIRS = 735;
  localparam int unsigned PosW        = 10;

  // Configuration register indexes.
  localparam logic [1:0] REG_TRACK_RATE     = 2'd0;
  localparam logic [1:0] REG_ESTIMATE_LIMIT = 2'd1;
  localparam logic [1:0] REG_GAIN           = 2'd2;

  localparam int unsigned CfgDataW = 23;

  localparam logic [15:0] TRACK_RATE_RESET     = 16'd262;
  localparam logic [22:0] ESTIMATE_LIMIT_RESET = 23'd131072;
  localparam logic [15:0] GAIN_RESET           = 16'd4096;

  typedef struct packed {
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
    logic               sample_present;
  } dcst_in_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               frame_last;
  } dcst_out_t;

  typedef struct packed {
    logic [15:0] track_rate;
    logic [22:0] estimate_limit;
    logic [15:0] gain;
  } dcst_cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/dcst_lane.sv
// ----------------------------------------------------------------------------
// dcst_lane: one channel of the DC tracker
// Holds the channel's DC estimate and runs the estimate update and the gain
// stage through one shared radix-4 shift-and-add multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module dcst_lane
  import dcst_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic               present_i,
  input  wire logic signed [15:0] sample_i,
  input  wire dcst_cfg_t          cfg_i,
  input  wire logic               ack_i,
  output logic                    idle_o,
  output logic                    done_o,
  output logic signed [15:0]      result_o
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_LOAD = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_RND  = 7'b0001000,
    ST_LIM  = 7'b0010000,
    ST_FIN  = 7'b0100000,
    ST_DONE = 7'b1000000
  } lane_state_e;

  lane_state_e        state_q, state_d;
  logic               phase_q, phase_d;
  logic [2:0]         cnt_q, cnt_d;
  logic signed [23:0] est_q, est_d;
  logic signed [15:0] sample_q, sample_d;
  logic               neg_q, neg_d;
  logic [47:0]        mcand_q, mcand_d;
  logic [15:0]        mplier_q, mplier_d;
  logic [47:0]        acc_q, acc_d;
  logic signed [33:0] enew_q, enew_d;
  logic signed [15:0] result_q, result_d;

  // Difference of the scaled sample and the estimate, in both signs.
  logic signed [32:0] xs33, e33, diff, ndiff;
  logic [32:0]        diff_mag;
  logic [47:0]        pp;
  logic [31:0]        upd_r;
  logic signed [33:0] e34;
  logic [33:0]        enew_mag;
  logic [19:0]        out_r;

  assign xs33     = {sample_q[15], sample_q, 16'd0};
  assign e33      = {{9{est_q[23]}}, est_q};
  assign diff     = xs33 - e33;
  assign ndiff    = e33 - xs33;
  assign diff_mag = diff[32] ? ndiff : diff;

  assign pp = (mplier_q[0] ? mcand_q : 48'd0) + (mplier_q[1] ? {mcand_q[46:0], 1'b0} : 48'd0);

  // The rounding bias is preloaded into the accumulator.
  assign upd_r    = acc_q[47:16];
  assign e34      = {{10{est_q[23]}}, est_q};
  assign enew_mag = enew_q[33] ? 34'(-enew_q) : 34'(enew_q);
  assign out_r    = acc_q[47:28];

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    est_d    = est_q;
    sample_d = sample_q;
    neg_d    = neg_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    enew_d   = enew_q;
    result_d = result_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          sample_d = sample_i;
          phase_d  = 1'b0;
          if (present_i) begin
            state_d = ST_LOAD;
          end else begin
            result_d = 16'sd0;
            state_d  = ST_DONE;
          end
        end
      end
      ST_LOAD: begin
        neg_d    = diff[32];
        mcand_d  = {15'd0, diff_mag};
        mplier_d = phase_q ? cfg_i.gain : cfg_i.track_rate;
        acc_d    = phase_q ? (48'd1 << 27) : (48'd1 << 15);
        cnt_d    = 3'd0;
        state_d  = ST_MUL;
      end
      ST_MUL: begin
        acc_d    = acc_q + pp;
        mcand_d  = {mcand_q[45:0], 2'b00};
        mplier_d = {2'b00, mplier_q[15:2]};
        cnt_d    = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          state_d = phase_q ? ST_FIN : ST_RND;
        end
      end
      ST_RND: begin
        enew_d  = neg_q ? (e34 - $signed({2'b00, upd_r})) : (e34 + $signed({2'b00, upd_r}));
        state_d = ST_LIM;
      end
      ST_LIM: begin
        if (enew_mag >= {11'd0, cfg_i.estimate_limit}) begin
          est_d = 24'sd0;
        end else begin
          est_d = enew_q[23:0];
        end
        phase_d = 1'b1;
        state_d = ST_LOAD;
      end
      ST_FIN: begin
        if (!neg_q) begin
          result_d = (out_r > 20'd32767) ? 16'sd32767 : $signed(out_r[15:0]);
        end else begin
          result_d = (out_r >= 20'd32768) ? -16'sd32768 : $signed(-out_r[15:0]);
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (ack_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= 1'b0;
      cnt_q   <= 3'd0;
      est_q   <= 24'sd0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      est_q   <= est_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    neg_q    <= neg_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
    enew_q   <= enew_d;
    result_q <= result_d;
  end

  assign idle_o   = (state_q == ST_IDLE);
  assign done_o   = (state_q == ST_DONE);
  assign result_o = result_q;

endmodule

`default_nettype wire

>>> hw/rtl/stereo_dc_tracker_gain_saturate.sv
// ----------------------------------------------------------------------------
// stereo_dc_tracker_gain_saturate: DC removal, gain and saturation for stereo
// Removes a tracked DC offset from each channel of a stereo pair, applies the
// output gain and saturates the result to 16 bits.
// ----------------------------------------------------------------------------
// Each accepted item is one stereo pair. Both channels are worked on at once
// in two lanes, each with a radix-4 shift-and-add multiplier that consumes two
// multiplier bits per cycle. A present pair passes through the lane states
// load, multiply (estimate update), round, limit check, load, multiply (gain)
// and finish. The lanes then hold the result in their done state until it
// moves into the output register, and return to idle before they can take
// the next item, so a new pair is accepted only once both lanes are idle.
// An absent pair skips the multiplier and goes straight to the done state
// with a zero result. The output register lets a new item be accepted
// while the previous result still waits to be taken. Configuration registers
// are written through a plain write port and should only be changed while the
// block is idle.
`default_nettype none

module stereo_dc_tracker_gain_saturate
  import dcst_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire dcst_in_t            in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output dcst_out_t                out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers.
  dcst_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TRACK_RATE:     cfg_d.track_rate     = cfg_data_i[15:0];
        REG_ESTIMATE_LIMIT: cfg_d.estimate_limit = cfg_data_i[22:0];
        REG_GAIN:           cfg_d.gain           = cfg_data_i[15:0];
        default: begin
          // Writes beyond the register list are ignored.
        end
      endcase
    end
  end

  // Frame position advances on every accepted item, present or not.
  logic [PosW-1:0] pos_q, pos_d;
  logic            last_now;
  logic            last_q, last_d;
  logic            in_fire;

  assign in_fire  = in_valid_i && in_ready_o;
  assign last_now = ({1'b0, pos_q} + 11'd1) >= 11'(FRAME_PAIRS);

  always_comb begin
    pos_d  = pos_q;
    last_d = last_q;
    if (in_fire) begin
      last_d = last_now;
      pos_d  = last_now ? '0 : (pos_q + 10'd1);
    end
  end

  // The two channel lanes always run in lock step.
  logic               left_idle, right_idle;
  logic               left_done, right_done;
  logic signed [15:0] left_res, right_res;
  logic               lanes_done, ack;

  dcst_lane u_left (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_fire),
    .present_i (in_data_i.sample_present),
    .sample_i  (in_data_i.left_in),
    .cfg_i     (cfg_q),
    .ack_i     (ack),
    .idle_o    (left_idle),
    .done_o    (left_done),
    .result_o  (left_res)
  );

  dcst_lane u_right (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_fire),
    .present_i (in_data_i.sample_present),
    .sample_i  (in_data_i.right_in),
    .cfg_i     (cfg_q),
    .ack_i     (ack),
    .idle_o    (right_idle),
    .done_o    (right_done),
    .result_o  (right_res)
  );

  assign in_ready_o = left_idle && right_idle;
  assign lanes_done = left_done && right_done;

  // A finished pair moves to the output register when it is free or emptying.
  logic      out_valid_q, out_valid_d;
  dcst_out_t out_q, out_d;

  assign ack = lanes_done && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (ack) begin
      out_valid_d      = 1'b1;
      out_d.left_out   = left_res;
      out_d.right_out  = right_res;
      out_d.frame_last = last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.track_rate     <= TRACK_RATE_RESET;
      cfg_q.estimate_limit <= ESTIMATE_LIMIT_RESET;
      cfg_q.gain           <= GAIN_RESET;
      pos_q                <= '0;
      out_valid_q          <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
